/* rtl/task_cpu_usage_accounting_defines.svh */
// assertion macros for the cpu usage accounting block
// used by task_cpu_usage_accounting.sv; no other dependencies
`ifndef TASK_CPU_USAGE_ACCOUNTING_DEFINES_SVH
`define TASK_CPU_USAGE_ACCOUNTING_DEFINES_SVH
`ifndef SYNTHESIS
`define TCUA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TCUA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TCUA_ASSERT_IMP(lbl, ante, cons, msg)
`define TCUA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/tcua_pkg.sv */
// shared types and codes for the cpu usage accounting block
// no dependencies
package tcua_pkg;

    localparam int TIME_W   = 48;
    localparam int SCALE_W  = 17;
    localparam int CFG_IDX_W = 4;

    localparam logic [1:0] CMD_SWITCH = 2'd0;
    localparam logic [1:0] CMD_STATUS = 2'd1;
    localparam logic [1:0] CMD_SYSQ   = 2'd2;
    localparam logic [1:0] CMD_TASK   = 2'd3;

    localparam logic [1:0] MODE_RING  = 2'd0;
    localparam logic [1:0] MODE_LAST  = 2'd1;
    localparam logic [1:0] MODE_PART  = 2'd2;
    localparam logic [1:0] MODE_TOTAL = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_IDX  = 2'd1;
    localparam logic [1:0] STAT_NOT_LIVE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDLE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CORR   = 4'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CL_RD,
        S_CL_CMP,
        S_CL_WR,
        S_SW_SET,
        S_SNAP_RD,
        S_SNAP_WR,
        S_SUM_A,
        S_SUM_B,
        S_SUM_C,
        S_FIN,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

endpackage

/* rtl/task_cpu_usage_accounting.sv */
// per-task cpu time accounting with a ring of history snapshots
// depends on tcua_pkg and task_cpu_usage_accounting_defines.svh
//
// usage: an item is taken when start is high and busy is low. switch and status
// items give no result; query items give one result on o_usage/o_status, shown
// for one cycle with o_strobe. the receiver cannot stall the result.
// config writes go through i_cfg_valid/o_cfg_ready (always ready), index and data.
// steps: a switch item folds any open interval into the running task's total,
//   opens one for the new task and, when more than the snapshot period has
//   passed, copies every task's total into the current history slot and
//   advances the ring. a query item folds and reopens any open interval, walks
//   every task over the totals and history memories, then runs the bit-serial
//   multiply and divide unit unless the summed window is zero or the part
//   exceeds it; the result strobe is in the last state. a task query with a
//   bad index or dead task skips the walk.
// reset: synchronous, active low. after reset the block clears the totals and
// history memories with busy high; config writes are taken as ever.
`include "task_cpu_usage_accounting_defines.svh"
module task_cpu_usage_accounting #(
    parameter int MAX_TASKS     = 16,
    parameter int HISTORY_SLOTS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [47:0] i_time_us,
    input  logic [3:0]  i_task_index,
    input  logic [1:0]  i_window_mode,
    input  logic        i_task_live,
    output logic        o_strobe,
    output logic [16:0] o_usage,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int TIME_W  = tcua_pkg::TIME_W;
    localparam int SCALE_W = tcua_pkg::SCALE_W;
    localparam int TW      = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int SW      = $clog2(HISTORY_SLOTS);
    localparam int HAW     = TW + SW;
    localparam int HD      = MAX_TASKS << SW;
    localparam int SUMW    = TIME_W + TW;
    localparam int PW      = SUMW + SCALE_W;
    localparam int CW      = $clog2(PW + 1);

    tcua_pkg::t_state r_state, n_state;

    logic [1:0]         r_cmd;
    logic [TIME_W-1:0]  r_time;
    logic [TIME_W-1:0]  r_t;
    logic [3:0]         r_idx;
    logic [1:0]         r_mode;
    logic [1:0]         r_st;
    logic [SCALE_W-1:0] r_usage;
    logic [TW-1:0]      r_run;
    logic [SW-1:0]      r_slot;
    logic [TIME_W-1:0]  r_last;
    logic               r_open  [MAX_TASKS];
    logic               r_alive [MAX_TASKS];
    logic               r_ran   [MAX_TASKS];
    logic [3:0]         r_idle;
    logic [31:0]        r_period;
    logic [SCALE_W-1:0] r_scale;
    logic [31:0]        r_corr;
    logic [TW-1:0]      r_k;
    logic [HAW-1:0]     r_clr;
    logic [TIME_W-1:0]  r_x;
    logic [SUMW-1:0]    r_all;
    logic [TIME_W-1:0]  r_part;
    logic [PW-1:0]      r_prod;
    logic [PW-1:0]      r_add;
    logic [SCALE_W-1:0] r_m;
    logic [CW-1:0]      r_cnt;
    logic [SUMW-1:0]    r_rem;
    logic [SCALE_W-1:0] r_q;

    logic [TIME_W-1:0]  r_total_mem [MAX_TASKS];
    logic [TIME_W-1:0]  r_start_mem [MAX_TASKS];
    logic [TIME_W-1:0]  r_hist_mem  [HD];
    logic [TIME_W-1:0]  r_total_rd;
    logic [TIME_W-1:0]  r_start_rd;
    logic [TIME_W-1:0]  r_hist_rd;

    logic               total_we, start_we, hist_we;
    logic [TW-1:0]      total_wa, total_ra, start_wa;
    logic [TIME_W-1:0]  total_wd, start_wd, hist_wd;
    logic [HAW-1:0]     hist_wa, hist_ra;

    logic               accept, in_ok;
    logic [TW-1:0]      in_t;
    logic [SW-1:0]      slot_c, slot_pp, slot_a, slot_b;
    logic               k_last, snap_due, all_zero, part_gt, go_mul;
    logic [TIME_W-1:0]  win, win_y;
    logic               incl, tgt, idle_ok;
    logic [SUMW:0]      rem2;
    logic               ge;
    logic [SCALE_W-1:0] q_next;

    assign accept      = start && !busy;
    assign busy        = (r_state != tcua_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = (r_state == tcua_pkg::S_DONE);
    assign o_usage     = r_usage;
    assign o_status    = r_st;

    assign in_ok   = (int'(i_task_index) < MAX_TASKS);
    assign in_t    = TW'(i_task_index);
    assign idle_ok = (int'(r_idle) < MAX_TASKS);
    assign k_last  = (r_k == TW'(MAX_TASKS - 1));

    // ring positions: slot before current, and the one before that
    assign slot_c  = (r_slot == '0) ? SW'(HISTORY_SLOTS - 1) : r_slot - 1'b1;
    assign slot_pp = (slot_c == '0) ? SW'(HISTORY_SLOTS - 1) : slot_c - 1'b1;
    assign slot_a  = slot_c;
    always_comb begin
        case (r_mode)
            tcua_pkg::MODE_LAST: slot_b = slot_pp;
            tcua_pkg::MODE_PART: slot_b = slot_c;
            default:             slot_b = r_slot;
        endcase
    end

    assign snap_due = ((r_t - r_last) > TIME_W'(r_period));
    assign win_y    = (r_mode == tcua_pkg::MODE_TOTAL) ? '0 : r_hist_rd;
    assign win      = r_x - win_y;
    assign incl     = (r_cmd == tcua_pkg::CMD_SYSQ) || r_alive[r_k];
    assign tgt      = (r_cmd == tcua_pkg::CMD_SYSQ) ? (idle_ok && (r_k == TW'(r_idle)))
                                                    : (r_k == TW'(r_idx));
    assign all_zero = (r_all == '0);
    assign part_gt  = (SUMW'(r_part) > r_all);
    assign go_mul   = !all_zero && !part_gt;

    // restoring divide step
    assign rem2   = {r_rem, r_prod[PW-1]};
    assign ge     = (rem2 >= {1'b0, r_all});
    assign q_next = {r_q[SCALE_W-2:0], ge};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tcua_pkg::S_CLEAR: begin
                if (r_clr == HAW'(HD - 1)) n_state = tcua_pkg::S_IDLE;
            end
            tcua_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_command)
                        tcua_pkg::CMD_SWITCH: begin
                            if (!in_ok) n_state = tcua_pkg::S_IDLE;
                            else if (r_open[r_run]) n_state = tcua_pkg::S_CL_RD;
                            else n_state = tcua_pkg::S_SW_SET;
                        end
                        tcua_pkg::CMD_STATUS: n_state = tcua_pkg::S_IDLE;
                        tcua_pkg::CMD_SYSQ: begin
                            n_state = r_open[r_run] ? tcua_pkg::S_CL_RD : tcua_pkg::S_SUM_A;
                        end
                        default: begin
                            if (!(in_ok && r_alive[in_t] && r_ran[in_t]))
                                n_state = tcua_pkg::S_DONE;
                            else
                                n_state = r_open[r_run] ? tcua_pkg::S_CL_RD
                                                        : tcua_pkg::S_SUM_A;
                        end
                    endcase
                end
            end
            tcua_pkg::S_CL_RD:  n_state = tcua_pkg::S_CL_CMP;
            tcua_pkg::S_CL_CMP: n_state = tcua_pkg::S_CL_WR;
            tcua_pkg::S_CL_WR: begin
                n_state = (r_cmd == tcua_pkg::CMD_SWITCH) ? tcua_pkg::S_SW_SET
                                                          : tcua_pkg::S_SUM_A;
            end
            tcua_pkg::S_SW_SET: n_state = snap_due ? tcua_pkg::S_SNAP_RD : tcua_pkg::S_IDLE;
            tcua_pkg::S_SNAP_RD: n_state = tcua_pkg::S_SNAP_WR;
            tcua_pkg::S_SNAP_WR: n_state = k_last ? tcua_pkg::S_IDLE : tcua_pkg::S_SNAP_RD;
            tcua_pkg::S_SUM_A:  n_state = tcua_pkg::S_SUM_B;
            tcua_pkg::S_SUM_B:  n_state = tcua_pkg::S_SUM_C;
            tcua_pkg::S_SUM_C:  n_state = k_last ? tcua_pkg::S_FIN : tcua_pkg::S_SUM_A;
            tcua_pkg::S_FIN:    n_state = go_mul ? tcua_pkg::S_MUL : tcua_pkg::S_DONE;
            tcua_pkg::S_MUL: begin
                if (r_cnt == CW'(SCALE_W - 1)) n_state = tcua_pkg::S_DIV;
            end
            tcua_pkg::S_DIV: begin
                if (r_cnt == CW'(PW - 1)) n_state = tcua_pkg::S_DONE;
            end
            tcua_pkg::S_DONE:   n_state = tcua_pkg::S_IDLE;
            default:            n_state = tcua_pkg::S_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        total_we = 1'b0;
        total_wa = r_run;
        total_wd = r_total_rd + (r_t - r_start_rd);
        total_ra = r_run;
        start_we = 1'b0;
        start_wa = r_run;
        start_wd = r_time;
        hist_we  = 1'b0;
        hist_wa  = {r_k, r_slot};
        hist_wd  = r_total_rd;
        hist_ra  = {r_k, slot_a};
        case (r_state)
            tcua_pkg::S_CLEAR: begin
                total_we = 1'b1;
                total_wa = r_clr[HAW-1 -: TW];
                total_wd = '0;
                hist_we  = 1'b1;
                hist_wa  = r_clr;
                hist_wd  = '0;
            end
            tcua_pkg::S_CL_WR: begin
                total_we = 1'b1;
                // a query reopens the interval at the uncorrected time
                start_we = (r_cmd != tcua_pkg::CMD_SWITCH);
            end
            tcua_pkg::S_SW_SET: begin
                start_we = 1'b1;
                start_wa = TW'(r_idx);
                start_wd = r_t;
            end
            tcua_pkg::S_SNAP_RD: total_ra = r_k;
            tcua_pkg::S_SNAP_WR: hist_we  = 1'b1;
            tcua_pkg::S_SUM_A:   total_ra = r_k;
            tcua_pkg::S_SUM_B:   hist_ra  = {r_k, slot_b};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (total_we) r_total_mem[total_wa] <= total_wd;
        r_total_rd <= r_total_mem[total_ra];
    end

    always_ff @(posedge i_clk) begin
        if (start_we) r_start_mem[start_wa] <= start_wd;
        r_start_rd <= r_start_mem[r_run];
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) r_hist_mem[hist_wa] <= hist_wd;
        r_hist_rd <= r_hist_mem[hist_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tcua_pkg::S_CLEAR;
            r_clr    <= '0;
            r_idle   <= 4'd0;
            r_period <= 32'd1000000;
            r_scale  <= 17'd1000;
            r_corr   <= 32'd1000;
            r_run    <= '0;
            r_slot   <= '0;
            r_last   <= '0;
            r_open   <= '{default: 1'b0};
            r_alive  <= '{default: 1'b0};
            r_ran    <= '{default: 1'b0};
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    tcua_pkg::CFG_IDLE:   r_idle   <= i_cfg_data[3:0];
                    tcua_pkg::CFG_PERIOD: r_period <= i_cfg_data;
                    tcua_pkg::CFG_SCALE:  r_scale  <= i_cfg_data[SCALE_W-1:0];
                    tcua_pkg::CFG_CORR:   r_corr   <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                tcua_pkg::S_CLEAR: r_clr <= r_clr + 1'b1;
                tcua_pkg::S_IDLE: begin
                    if (accept) begin
                        r_cmd   <= i_command;
                        r_time  <= i_time_us;
                        r_t     <= i_time_us;
                        r_idx   <= i_task_index;
                        r_mode  <= i_window_mode;
                        r_k     <= '0;
                        r_all   <= '0;
                        r_part  <= '0;
                        r_usage <= '0;
                        r_st    <= tcua_pkg::STAT_OK;
                        if (i_command == tcua_pkg::CMD_STATUS && in_ok)
                            r_alive[in_t] <= i_task_live;
                        if (i_command == tcua_pkg::CMD_TASK) begin
                            if (!in_ok) r_st <= tcua_pkg::STAT_BAD_IDX;
                            else if (!r_alive[in_t] || !r_ran[in_t])
                                r_st <= tcua_pkg::STAT_NOT_LIVE;
                        end
                    end
                end
                tcua_pkg::S_CL_CMP: begin
                    // time went backwards: apply tick correction
                    if (r_t < r_start_rd) r_t <= r_t + TIME_W'(r_corr);
                end
                tcua_pkg::S_CL_WR: begin
                    if (r_cmd == tcua_pkg::CMD_SWITCH) r_open[r_run] <= 1'b0;
                end
                tcua_pkg::S_SW_SET: begin
                    r_run               <= TW'(r_idx);
                    r_open[TW'(r_idx)]  <= 1'b1;
                    r_ran[TW'(r_idx)]   <= 1'b1;
                    r_k                 <= '0;
                    if (snap_due) r_last <= r_t;
                end
                tcua_pkg::S_SNAP_WR: begin
                    r_k <= r_k + 1'b1;
                    if (k_last)
                        r_slot <= (int'(r_slot) == HISTORY_SLOTS - 1) ? '0 : r_slot + 1'b1;
                end
                tcua_pkg::S_SUM_B: begin
                    r_x <= (r_mode == tcua_pkg::MODE_LAST) ? r_hist_rd : r_total_rd;
                end
                tcua_pkg::S_SUM_C: begin
                    if (incl) r_all <= r_all + SUMW'(win);
                    if (tgt) r_part <= win;
                    r_k <= r_k + 1'b1;
                end
                tcua_pkg::S_FIN: begin
                    r_prod <= '0;
                    r_add  <= PW'(r_part);
                    r_m    <= r_scale;
                    r_cnt  <= '0;
                    if (!go_mul && r_cmd == tcua_pkg::CMD_TASK && !all_zero)
                        r_usage <= r_scale;
                end
                tcua_pkg::S_MUL: begin
                    if (r_m[0]) r_prod <= r_prod + r_add;
                    r_add <= r_add << 1;
                    r_m   <= r_m >> 1;
                    if (r_cnt == CW'(SCALE_W - 1)) begin
                        r_cnt <= '0;
                        r_rem <= '0;
                        r_q   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                tcua_pkg::S_DIV: begin
                    r_rem  <= ge ? SUMW'(rem2 - {1'b0, r_all}) : SUMW'(rem2);
                    r_q    <= q_next;
                    r_prod <= r_prod << 1;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CW'(PW - 1))
                        r_usage <= (r_cmd == tcua_pkg::CMD_SYSQ) ? r_scale - q_next : q_next;
                end
                default: ;
            endcase
        end
    end

    `TCUA_ASSERT_IMP(a_slot_range, 1'b1, int'(r_slot) < HISTORY_SLOTS, "history slot out of range")
    `TCUA_ASSERT_NXT(a_strobe_pulse, o_strobe, !o_strobe, "result strobe longer than one cycle")
    `TCUA_ASSERT_IMP(a_div_rem, r_state == tcua_pkg::S_DIV, r_rem < r_all, "divider remainder not below divisor")
    `TCUA_ASSERT_IMP(a_err_cmd, o_strobe && (o_status != tcua_pkg::STAT_OK), r_cmd == tcua_pkg::CMD_TASK, "error status on a system query")

endmodule
